>>> sv/ipc_pkg.sv
package ipc_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX       = 3'd4;

    localparam int BOUND_W = 16;
    localparam int DRIVE_W = 28;
    localparam int DRIVE_FRAC = 12;
    localparam int SUM_FRAC = 20;
    localparam int BOUND_EXT_W = BOUND_W + SUM_FRAC;

    localparam logic [BOUND_W-1:0] OUT_MIN_RESET = 16'd0;
    localparam logic [BOUND_W-1:0] OUT_MAX_RESET = 16'hFFFF;
    localparam logic [DRIVE_W-1:0] ROUND_HALF = 28'd2048;

endpackage

>>> sv/incremental_pi_controller_core.sv
// A new error sample is accepted only in the idle state, once the previous result is on
// the output; a single shared multiplier forms sample_period*gain_i, the two halves of
// that product times the error, and the proportional term in turn, with an add into one
// accumulator after each error product. The clamp step waits while a prior result is unread.
// Reset (async, active low) restores register defaults and clears stored error and drive.
module incremental_pi_controller_core
    import ipc_pkg::*;
#(
    parameter int ERROR_WIDTH = 16,
    parameter int GAIN_WIDTH  = 16
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                           cfg_index,
    input  logic [((GAIN_WIDTH > BOUND_W) ? GAIN_WIDTH : BOUND_W)-1:0] cfg_data,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic signed [ERROR_WIDTH-1:0]                    error_in,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [BOUND_W-1:0]                               drive_out
);

    localparam int GW = GAIN_WIDTH;
    localparam int EW = ERROR_WIDTH;
    localparam int MW = ((GW > EW) ? GW : EW) + 1;
    localparam int PW = GW + 1 + MW;
    localparam int ACC_MIN = 2 * GW + EW + 3;
    localparam int ACC_W = (ACC_MIN > BOUND_EXT_W + 2) ? ACC_MIN : BOUND_EXT_W + 2;
    localparam logic [GW-1:0] GAIN_P_RESET = GW'(256);
    localparam logic [GW-1:0] GAIN_I_RESET = '0;
    localparam logic [GW-1:0] PERIOD_RESET = GW'(256);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_TI,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_KP,
        ST_ADD_KP,
        ST_CLAMP
    } state_t;

    state_t                    state_reg, state_next;
    logic [GW-1:0]             gain_p_reg, gain_p_next;
    logic [GW-1:0]             gain_i_reg, gain_i_next;
    logic [GW-1:0]             period_reg, period_next;
    logic [BOUND_W-1:0]        out_min_reg, out_min_next;
    logic [BOUND_W-1:0]        out_max_reg, out_max_next;
    logic signed [EW-1:0]      error_reg, error_next;
    logic signed [EW-1:0]      prev_error_reg, prev_error_next;
    logic [DRIVE_W-1:0]        prev_drive_reg, prev_drive_next;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic [GW-1:0]             ti_hi_reg, ti_hi_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [BOUND_W-1:0]        drive_reg, drive_next;

    logic [GW-1:0]             mul_a;
    logic signed [GW:0]        mul_a_s;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_p;
    logic signed [EW:0]        error_diff;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   hi_ext;
    logic signed [ACC_W-1:0]   lo_ext;
    logic [BOUND_EXT_W-1:0]    clamped;
    logic [DRIVE_W-1:0]        drive_new;
    logic [DRIVE_W-1:0]        drive_round;
    logic                      in_fire;
    logic                      clamp_go;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign drive_out = drive_reg;
    assign clamp_go  = !out_valid_reg || out_ready;

    assign error_diff = {error_reg[EW-1], error_reg} - {prev_error_reg[EW-1], prev_error_reg};
    assign mul_a_s    = {1'b0, mul_a};
    assign mul_p      = mul_a_s * mul_b;
    assign prod_ext   = ACC_W'(prod_reg);
    assign hi_ext     = ACC_W'({out_max_reg, {SUM_FRAC{1'b0}}});
    assign lo_ext     = ACC_W'({out_min_reg, {SUM_FRAC{1'b0}}});

    always_comb
    begin
        case (state_reg)
            ST_MUL_TI:
            begin
                mul_a = period_reg;
                mul_b = MW'({1'b0, gain_i_reg});
            end
            ST_MUL_LO:
            begin
                mul_a = prod_reg[GW-1:0];
                mul_b = MW'(error_reg);
            end
            ST_MUL_HI:
            begin
                mul_a = ti_hi_reg;
                mul_b = MW'(error_reg);
            end
            default:
            begin
                mul_a = gain_p_reg;
                mul_b = MW'(error_diff);
            end
        endcase
    end

    always_comb
    begin
        if (acc_reg > hi_ext)
            clamped = BOUND_EXT_W'(hi_ext);
        else if (acc_reg < lo_ext)
            clamped = BOUND_EXT_W'(lo_ext);
        else
            clamped = acc_reg[BOUND_EXT_W-1:0];
        drive_new   = clamped[BOUND_EXT_W-1:BOUND_EXT_W-DRIVE_W];
        drive_round = drive_new + ROUND_HALF;
    end

    always_comb
    begin
        state_next      = state_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        period_next     = period_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        error_next      = error_reg;
        prev_error_next = prev_error_reg;
        prev_drive_next = prev_drive_reg;
        prod_next       = prod_reg;
        ti_hi_next      = ti_hi_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        drive_next      = drive_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:        gain_p_next  = cfg_data[GW-1:0];
                REG_GAIN_I:        gain_i_next  = cfg_data[GW-1:0];
                REG_SAMPLE_PERIOD: period_next  = cfg_data[GW-1:0];
                REG_OUT_MIN:       out_min_next = cfg_data[BOUND_W-1:0];
                REG_OUT_MAX:       out_max_next = cfg_data[BOUND_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    error_next = error_in;
                    acc_next   = ACC_W'({prev_drive_reg, 8'b0});
                    state_next = ST_MUL_TI;
                end
            end
            ST_MUL_TI:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                ti_hi_next = prod_reg[2*GW-1:GW];
                prod_next  = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                acc_next   = acc_reg + prod_ext;
                prod_next  = mul_p;
                state_next = ST_MUL_KP;
            end
            ST_MUL_KP:
            begin
                acc_next   = acc_reg + (prod_ext <<< GW);
                prod_next  = mul_p;
                state_next = ST_ADD_KP;
            end
            ST_ADD_KP:
            begin
                acc_next   = acc_reg + (prod_ext <<< 8);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (clamp_go)
                begin
                    prev_drive_next = drive_new;
                    prev_error_next = error_reg;
                    drive_next      = drive_round[DRIVE_W-1:DRIVE_FRAC];
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gain_p_reg     <= GAIN_P_RESET;
            gain_i_reg     <= GAIN_I_RESET;
            period_reg     <= PERIOD_RESET;
            out_min_reg    <= OUT_MIN_RESET;
            out_max_reg    <= OUT_MAX_RESET;
            prev_error_reg <= '0;
            prev_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            period_reg     <= period_next;
            out_min_reg    <= out_min_next;
            out_max_reg    <= out_max_next;
            prev_error_reg <= prev_error_next;
            prev_drive_reg <= prev_drive_next;
            out_valid_reg  <= out_valid_next;
            drive_reg      <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        error_reg <= error_next;
        prod_reg  <= prod_next;
        ti_hi_reg <= ti_hi_next;
        acc_reg   <= acc_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a beat is in flight");

    a_result_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_CLAMP))
        else $error("result beat raised outside the clamp step");

    a_result_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLAMP && clamp_go && out_min_reg <= out_max_reg
        |=> drive_out >= $past(out_min_reg) && drive_out <= $past(out_max_reg))
        else $error("drive outside clamp bounds");

endmodule
